@@ hdl/multi_queue_byte_ring_buffer_macros.svh @@
// Assertion macros used by the ring buffer datapath.
`ifndef MULTI_QUEUE_BYTE_RING_BUFFER_MACROS_SVH
`define MULTI_QUEUE_BYTE_RING_BUFFER_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define MQRB_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define MQRB_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hdl/mqrb_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
package mqrb_pkg;

    localparam int N_REGS          = 4;
    localparam int DEF_NUM_QUEUES  = 4;
    localparam int DEF_QUEUE_DEPTH = 64;
    localparam int CFG_W           = 7;
    localparam int QID_W           = 2;
    localparam int BYTE_W          = 8;

    typedef enum logic [1:0] {
        ACT_WRITE    = 2'd0,
        ACT_READ     = 2'd1,
        ACT_READ_ALL = 2'd2,
        ACT_CLEAR    = 2'd3
    } t_action;

    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_ABSENT = 2'd1,
        ST_FULL   = 2'd2,
        ST_EMPTY  = 2'd3
    } t_status;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic accept;     // input word taken this cycle
        logic ld_direct;  // load the immediate result into the output register
        logic rd_in;      // read the store at the addressed queue's head
        logic ld_mem;     // load the fetched byte into the output register
        logic rd_pos;     // fetch the next byte of a drain
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic out_free;   // output register empty or being taken
        logic read_start; // the input word reads bytes from a non-empty queue
        logic xfer_last;  // the byte being delivered is the final one
    } t_stat;

endpackage
`default_nettype wire

@@ hdl/mqrb_ctrl.sv @@
`timescale 1ns / 1ps
`default_nettype none
module mqrb_ctrl (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_in_valid,
    output logic               o_in_stall,
    input  wire mqrb_pkg::t_stat i_stat,
    output mqrb_pkg::t_cmd     o_cmd
);

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_XFER = 2'b10
    } t_state;

    t_state r_state, n_state;

    always_comb begin
        o_cmd      = '0;
        o_in_stall = 1'b1;
        n_state    = r_state;
        case (r_state)
            S_IDLE: begin
                o_in_stall = !i_stat.out_free;
                if (i_in_valid && i_stat.out_free) begin
                    o_cmd.accept = 1'b1;
                    if (i_stat.read_start) begin
                        o_cmd.rd_in = 1'b1;
                        n_state     = S_XFER;
                    end else begin
                        o_cmd.ld_direct = 1'b1;
                    end
                end
            end
            S_XFER: begin
                // Each delivered byte launches the fetch of the one after it.
                if (i_stat.out_free) begin
                    o_cmd.ld_mem = 1'b1;
                    if (i_stat.xfer_last) begin
                        n_state = S_IDLE;
                    end else begin
                        o_cmd.rd_pos = 1'b1;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule
`default_nettype wire

@@ hdl/mqrb_datapath.sv @@
`timescale 1ns / 1ps
`default_nettype none
`include "multi_queue_byte_ring_buffer_macros.svh"
module mqrb_datapath #(
    parameter int NUM_QUEUES  = mqrb_pkg::DEF_NUM_QUEUES,
    parameter int QUEUE_DEPTH = mqrb_pkg::DEF_QUEUE_DEPTH
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic [1:0]                    i_action,
    input  wire logic [mqrb_pkg::QID_W-1:0]    i_queue_id,
    input  wire logic [mqrb_pkg::BYTE_W-1:0]   i_data_in,
    input  wire logic                          i_cfg_we,
    input  wire logic [mqrb_pkg::QID_W-1:0]    i_cfg_idx,
    input  wire logic [mqrb_pkg::CFG_W-1:0]    i_cfg_data,
    input  wire logic                          i_out_stall,
    input  wire mqrb_pkg::t_cmd                i_cmd,
    output mqrb_pkg::t_stat                    o_stat,
    output logic                               o_out_valid,
    output logic [1:0]                         o_status,
    output logic [mqrb_pkg::BYTE_W-1:0]        o_data_out,
    output logic                               o_last
);

    localparam int PW    = $clog2(QUEUE_DEPTH);
    localparam int LW    = $clog2(QUEUE_DEPTH + 1);
    localparam int AW    = mqrb_pkg::QID_W + PW;
    localparam int DEPTH = 1 << AW;

    logic [LW-1:0] r_len  [mqrb_pkg::N_REGS];
    logic [PW-1:0] r_head [mqrb_pkg::N_REGS];
    logic [PW-1:0] r_tail [mqrb_pkg::N_REGS];

    logic [mqrb_pkg::BYTE_W-1:0] r_store [DEPTH];
    logic [mqrb_pkg::BYTE_W-1:0] r_rd_data;

    logic [mqrb_pkg::QID_W-1:0]  r_q;
    logic [PW-1:0]               r_pos;
    logic [PW-1:0]               r_cnt;

    logic                        r_out_valid;
    mqrb_pkg::t_status           r_status;
    logic [mqrb_pkg::BYTE_W-1:0] r_data;
    logic                        r_last;

    mqrb_pkg::t_action act;
    mqrb_pkg::t_status dir_status;
    logic [LW-1:0]     len_q;
    logic [PW-1:0]     head_q, tail_q, head_nx, tail_nx, pos_nx, count_q;
    logic [LW-1:0]     head_inc, tail_inc, pos_inc;
    logic              present, empty, full, wr_en, cfg_hit;
    logic [LW-1:0]     cfg_len;

    assign act     = mqrb_pkg::t_action'(i_action);
    assign len_q   = r_len[i_queue_id];
    assign head_q  = r_head[i_queue_id];
    assign tail_q  = r_tail[i_queue_id];
    assign present = (len_q != '0);
    assign empty   = (head_q == tail_q);

    assign head_inc = LW'(head_q) + LW'(1);
    assign tail_inc = LW'(tail_q) + LW'(1);
    assign pos_inc  = LW'(r_pos) + LW'(1);
    assign head_nx  = (head_inc == len_q) ? '0 : head_inc[PW-1:0];
    assign tail_nx  = (tail_inc == len_q) ? '0 : tail_inc[PW-1:0];
    assign pos_nx   = (pos_inc == r_len[r_q]) ? '0 : pos_inc[PW-1:0];
    assign full     = (tail_nx == head_q);

    // Stored bytes, following wraparound of the ring.
    always_comb begin
        logic [LW-1:0] diff;
        if (tail_q >= head_q) begin
            diff = LW'(tail_q) - LW'(head_q);
        end else begin
            diff = LW'(tail_q) + len_q - LW'(head_q);
        end
        count_q = diff[PW-1:0];
    end

    always_comb begin
        dir_status = mqrb_pkg::ST_OK;
        if (!present) begin
            dir_status = mqrb_pkg::ST_ABSENT;
        end else begin
            case (act)
                mqrb_pkg::ACT_WRITE: begin
                    if (full) dir_status = mqrb_pkg::ST_FULL;
                end
                mqrb_pkg::ACT_READ, mqrb_pkg::ACT_READ_ALL: begin
                    if (empty) dir_status = mqrb_pkg::ST_EMPTY;
                end
                default: begin
                    dir_status = mqrb_pkg::ST_OK;
                end
            endcase
        end
    end

    assign wr_en = i_cmd.accept && present && (act == mqrb_pkg::ACT_WRITE) && !full;

    assign o_stat.out_free   = !r_out_valid || !i_out_stall;
    assign o_stat.read_start = present && !empty &&
                               (act == mqrb_pkg::ACT_READ || act == mqrb_pkg::ACT_READ_ALL);
    assign o_stat.xfer_last  = (r_cnt == PW'(1));

    // Lengths above the queue depth act as the full depth.
    assign cfg_hit = i_cfg_we && (int'(i_cfg_idx) < NUM_QUEUES);
    assign cfg_len = (i_cfg_data > mqrb_pkg::CFG_W'(QUEUE_DEPTH)) ?
                     LW'(QUEUE_DEPTH) : i_cfg_data[LW-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < mqrb_pkg::N_REGS; k++) begin
                r_len[k]  <= '0;
                r_head[k] <= '0;
                r_tail[k] <= '0;
            end
        end else if (cfg_hit) begin
            r_len[i_cfg_idx]  <= cfg_len;
            r_head[i_cfg_idx] <= '0;
            r_tail[i_cfg_idx] <= '0;
        end else if (i_cmd.accept && present) begin
            case (act)
                mqrb_pkg::ACT_WRITE: begin
                    if (!full) r_tail[i_queue_id] <= tail_nx;
                end
                mqrb_pkg::ACT_READ: begin
                    if (!empty) r_head[i_queue_id] <= head_nx;
                end
                default: begin
                    r_head[i_queue_id] <= '0;
                    r_tail[i_queue_id] <= '0;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_store[{i_queue_id, tail_q}] <= i_data_in;
        end
        if (i_cmd.rd_in) begin
            r_rd_data <= r_store[{i_queue_id, head_q}];
        end else if (i_cmd.rd_pos) begin
            r_rd_data <= r_store[{r_q, r_pos}];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
            r_pos <= '0;
            r_q   <= '0;
        end else if (i_cmd.rd_in) begin
            r_q   <= i_queue_id;
            r_pos <= head_nx;
            r_cnt <= (act == mqrb_pkg::ACT_READ) ? PW'(1) : count_q;
        end else if (i_cmd.rd_pos) begin
            r_pos <= pos_nx;
            r_cnt <= r_cnt - PW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.ld_direct || i_cmd.ld_mem) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.ld_direct) begin
            r_status <= dir_status;
            r_data   <= '0;
            r_last   <= 1'b1;
        end else if (i_cmd.ld_mem) begin
            r_status <= mqrb_pkg::ST_OK;
            r_data   <= r_rd_data;
            r_last   <= o_stat.xfer_last;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_status    = r_status;
    assign o_data_out  = r_data;
    assign o_last      = r_last;

    `MQRB_ASSERT_SAME(a_xfer_count, i_clk, i_rst_n, i_cmd.ld_mem, r_cnt != '0, "byte delivered with no count left")
    `MQRB_ASSERT_SAME(a_load_free, i_clk, i_rst_n, i_cmd.ld_direct || i_cmd.ld_mem, o_stat.out_free, "output register overwritten")
    `MQRB_ASSERT_NEXT(a_drain_end, i_clk, i_rst_n, i_cmd.ld_mem && o_stat.xfer_last, !i_cmd.ld_mem, "transfer continued past the final byte")

endmodule
`default_nettype wire

@@ hdl/multi_queue_byte_ring_buffer.sv @@
`timescale 1ns / 1ps
`default_nettype none
// Write, clear and refused words give their result in the cycle after acceptance;
// a read gives its byte through the registered store read, then the output register.
// One word per cycle for write, clear and error results unless the output stalls;
// a read or read-all stalls new words until its bytes pass the single store read port.
// Reset is synchronous and active low: lengths and pointers go to zero, the byte store
// is not cleared and needs no clearing pass.
module multi_queue_byte_ring_buffer #(
    parameter int NUM_QUEUES  = mqrb_pkg::DEF_NUM_QUEUES,
    parameter int QUEUE_DEPTH = mqrb_pkg::DEF_QUEUE_DEPTH
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_in_valid,
    output logic                             o_in_stall,
    input  wire logic [1:0]                  i_action,
    input  wire logic [mqrb_pkg::QID_W-1:0]  i_queue_id,
    input  wire logic [mqrb_pkg::BYTE_W-1:0] i_data_in,
    output logic                             o_out_valid,
    input  wire logic                        i_out_stall,
    output logic [1:0]                       o_status,
    output logic [mqrb_pkg::BYTE_W-1:0]      o_data_out,
    output logic                             o_last,
    input  wire logic                        i_cfg_we,
    input  wire logic [mqrb_pkg::QID_W-1:0]  i_cfg_idx,
    input  wire logic [mqrb_pkg::CFG_W-1:0]  i_cfg_data
);

    mqrb_pkg::t_cmd  cmd;
    mqrb_pkg::t_stat stat;

    mqrb_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    mqrb_datapath #(
        .NUM_QUEUES  (NUM_QUEUES),
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_action    (i_action),
        .i_queue_id  (i_queue_id),
        .i_data_in   (i_data_in),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_out_stall (i_out_stall),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .o_out_valid (o_out_valid),
        .o_status    (o_status),
        .o_data_out  (o_data_out),
        .o_last      (o_last)
    );

endmodule
`default_nettype wire
